FILE: design/svtu_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the state value table update block
// no dependencies; used by the interfaces, the top level and the testbench
package svtu_pkg;

    // default sizing, handed down through the top level parameters
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_BOARD_CELLS = 9;

    // fixed field widths
    localparam int RET_W   = 2;
    localparam int VALUE_W = 18;
    localparam int VISIT_W = 16;
    localparam int STEP_W  = 16;
    localparam int INDEX_W = 10;
    localparam int PROD_W  = VALUE_W + STEP_W;

    // return codes as they arrive on the input
    localparam logic [RET_W-1:0] RET_DRAW = 2'b00;
    localparam logic [RET_W-1:0] RET_WIN  = 2'b01;

    // q1.16 constants
    localparam logic signed [VALUE_W-1:0] VALUE_ONE  = 18'sd65536;
    localparam logic signed [VALUE_W-1:0] VALUE_MONE = -18'sd65536;
    localparam logic [PROD_W:0]           ROUND_HALF = 35'd32768;

    // visit counter limit and configuration reset value
    localparam logic [VISIT_W-1:0] VISIT_MAX  = 16'hFFFF;
    localparam logic [VISIT_W-1:0] VISIT_ONE  = 16'd1;
    localparam logic [STEP_W-1:0]  STEP_RESET = 16'd655;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MUL,
        S_UPD,
        S_MISS
    } t_state;

endpackage

FILE: design/svtu_if.sv
`timescale 1ns / 1ps
// valid/ready channel interfaces: input item, result item and configuration write
// depends on svtu_pkg for field widths
interface svtu_in_if #(
    parameter int KEY_W = 2 * svtu_pkg::DEF_BOARD_CELLS
);
    logic                             valid;
    logic                             ready;
    logic [KEY_W-1:0]                 state_key;
    logic signed [svtu_pkg::RET_W-1:0] episode_return;

    modport source (output valid, output state_key, output episode_return, input ready);
    modport sink   (input valid, input state_key, input episode_return, output ready);
endinterface

interface svtu_out_if;
    logic                                valid;
    logic                                ready;
    logic [svtu_pkg::INDEX_W-1:0]        entry_index;
    logic                                was_new;
    logic signed [svtu_pkg::VALUE_W-1:0] value_after;
    logic [svtu_pkg::VISIT_W-1:0]        visits_after;
    logic                                table_full;

    modport source (output valid, output entry_index, output was_new, output value_after,
                    output visits_after, output table_full, input ready);
    modport sink   (input valid, input entry_index, input was_new, input value_after,
                    input visits_after, input table_full, output ready);
endinterface

interface svtu_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [svtu_pkg::STEP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: design/svtu_ram.sv
`timescale 1ns / 1ps
// simple dual port table ram: one write port, one registered read port
// no package dependencies
module svtu_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 52,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/state_value_table_update.sv
`timescale 1ns / 1ps
// top level of the state value table update block
// depends on svtu_pkg, the svtu interfaces and svtu_ram
//
// Usage
//   i_item carries a packed board key and a return of -1, 0 or +1. One transfer on
//   i_item produces exactly one transfer on o_result: the matched or new entry index,
//   a new-entry flag, the value and visit count after the update, or table_full when
//   a new key finds no free entry. i_cfg writes the step size (q0.16), taken at once.
//   Timing: the key store is read one entry a cycle through a single registered ram
//   port, over only the entries in use (up to TABLE_DEPTH). A hit then passes through
//   the 18 x 16 multiplier and then the round, add and write back step.
//   One item is in work at a time; i_item.ready is high only while the block is idle.
//   A finished result sits in an output register, so the next item may be taken while
//   it waits; the block only holds its write back when that register is still full.
//   Reset (synchronous, active low) empties the table and sets the step size to 655.
//   The ram needs no clearing pass: only entries below the fill count are ever read.
//   While o_result.ready is low a pending result is held unchanged.
module state_value_table_update #(
    parameter int TABLE_DEPTH = svtu_pkg::DEF_TABLE_DEPTH,
    parameter int BOARD_CELLS = svtu_pkg::DEF_BOARD_CELLS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    svtu_in_if.sink     i_item,
    svtu_cfg_if.sink    i_cfg,
    svtu_out_if.source  o_result
);

    localparam int KEY_W   = 2 * BOARD_CELLS;
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int VALUE_W = svtu_pkg::VALUE_W;
    localparam int VISIT_W = svtu_pkg::VISIT_W;
    localparam int STEP_W  = svtu_pkg::STEP_W;
    localparam int PROD_W  = svtu_pkg::PROD_W;
    localparam int INDEX_W = svtu_pkg::INDEX_W;
    localparam int ENTRY_W = KEY_W + VALUE_W + VISIT_W;
    localparam int DIFF_W  = VALUE_W + 1;
    localparam int SUM_W   = VALUE_W + 3;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

    // control registers
    svtu_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_used, n_used;
    logic [CNT_W-1:0] r_addr, n_addr;
    logic             r_pend, n_pend;
    logic [STEP_W-1:0] r_step;
    logic             r_o_valid, n_o_valid;

    // payload registers
    logic [KEY_W-1:0]          r_key, n_key;
    logic signed [VALUE_W-1:0] r_ret, n_ret;
    logic [IDX_W-1:0]          r_paddr, n_paddr;
    logic signed [VALUE_W-1:0] r_val, n_val;
    logic [VISIT_W-1:0]        r_vis, n_vis;
    logic                      r_neg, n_neg;
    logic [PROD_W-1:0]         r_prod, n_prod;
    logic [INDEX_W-1:0]        r_o_index, n_o_index;
    logic                      r_o_new, n_o_new;
    logic signed [VALUE_W-1:0] r_o_value, n_o_value;
    logic [VISIT_W-1:0]        r_o_visits, n_o_visits;
    logic                      r_o_full, n_o_full;

    // ram ports
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [ENTRY_W-1:0] ram_rdata;
    logic [KEY_W-1:0]          rd_key;
    logic signed [VALUE_W-1:0] rd_val;
    logic [VISIT_W-1:0]        rd_vis;

    // arithmetic
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-1:0]         mag;
    logic [PROD_W:0]           rounded;
    logic [DIFF_W-1:0]         move;
    logic signed [SUM_W-1:0]   sum;
    logic signed [VALUE_W-1:0] val_new;
    logic [VISIT_W-1:0]        vis_new;
    logic                      slot_free;

    svtu_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W),
        .ADDR_W(IDX_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(r_addr[IDX_W-1:0]),
        .o_rdata(ram_rdata)
    );

    assign rd_key = ram_rdata[ENTRY_W-1 -: KEY_W];
    assign rd_val = signed'(ram_rdata[VISIT_W +: VALUE_W]);
    assign rd_vis = ram_rdata[VISIT_W-1:0];

    // handshakes
    assign i_item.ready = (r_state == svtu_pkg::S_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign slot_free    = !r_o_valid || o_result.ready;
    assign ram_re       = (r_state == svtu_pkg::S_SCAN) && (r_addr < r_used);

    // difference to the return and its magnitude for the multiplier
    assign diff = DIFF_W'(r_ret) - DIFF_W'(r_val);
    assign mag  = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);

    // round to nearest, ties away from zero, then add and clamp
    assign rounded = {1'b0, r_prod} + svtu_pkg::ROUND_HALF;
    assign move    = rounded[16 +: DIFF_W];
    always_comb begin
        if (r_neg) begin
            sum = SUM_W'(r_val) - signed'(SUM_W'(move));
        end else begin
            sum = SUM_W'(r_val) + signed'(SUM_W'(move));
        end
        if (sum > SUM_W'(svtu_pkg::VALUE_ONE)) begin
            val_new = svtu_pkg::VALUE_ONE;
        end else if (sum < SUM_W'(svtu_pkg::VALUE_MONE)) begin
            val_new = svtu_pkg::VALUE_MONE;
        end else begin
            val_new = sum[VALUE_W-1:0];
        end
    end

    // saturating visit count
    assign vis_new = (r_vis == svtu_pkg::VISIT_MAX) ? r_vis : r_vis + svtu_pkg::VISIT_ONE;

    // sequencer: next state, datapath loads and ram write
    always_comb begin
        n_state    = r_state;
        n_used     = r_used;
        n_addr     = r_addr;
        n_pend     = r_pend;
        n_key      = r_key;
        n_ret      = r_ret;
        n_paddr    = r_paddr;
        n_val      = r_val;
        n_vis      = r_vis;
        n_neg      = r_neg;
        n_prod     = r_prod;
        n_o_valid  = r_o_valid && !o_result.ready;
        n_o_index  = r_o_index;
        n_o_new    = r_o_new;
        n_o_value  = r_o_value;
        n_o_visits = r_o_visits;
        n_o_full   = r_o_full;
        ram_we     = 1'b0;
        ram_waddr  = r_paddr;
        ram_wdata  = {r_key, r_ret, svtu_pkg::VISIT_ONE};

        unique case (r_state)
            svtu_pkg::S_IDLE: begin
                if (i_item.valid) begin
                    n_key  = i_item.state_key;
                    if (i_item.episode_return == svtu_pkg::RET_WIN) begin
                        n_ret = svtu_pkg::VALUE_ONE;
                    end else if (i_item.episode_return == svtu_pkg::RET_DRAW) begin
                        n_ret = '0;
                    end else begin
                        n_ret = svtu_pkg::VALUE_MONE;
                    end
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_state = svtu_pkg::S_SCAN;
                end
            end
            svtu_pkg::S_SCAN: begin
                if (r_pend && (rd_key == r_key)) begin
                    n_val   = rd_val;
                    n_vis   = rd_vis;
                    n_pend  = 1'b0;
                    n_state = svtu_pkg::S_MUL;
                end else if (r_addr < r_used) begin
                    n_pend  = 1'b1;
                    n_paddr = r_addr[IDX_W-1:0];
                    n_addr  = r_addr + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = svtu_pkg::S_MISS;
                end
            end
            svtu_pkg::S_MUL: begin
                n_neg   = diff[DIFF_W-1];
                n_prod  = mag[VALUE_W-1:0] * r_step;
                n_state = svtu_pkg::S_UPD;
            end
            svtu_pkg::S_UPD: begin
                if (slot_free) begin
                    ram_we     = 1'b1;
                    ram_waddr  = r_paddr;
                    ram_wdata  = {r_key, val_new, vis_new};
                    n_o_valid  = 1'b1;
                    n_o_index  = INDEX_W'(r_paddr);
                    n_o_new    = 1'b0;
                    n_o_value  = val_new;
                    n_o_visits = vis_new;
                    n_o_full   = 1'b0;
                    n_state    = svtu_pkg::S_IDLE;
                end
            end
            svtu_pkg::S_MISS: begin
                if (slot_free) begin
                    n_o_valid = 1'b1;
                    if (r_used == DEPTH_CNT) begin
                        n_o_index  = '0;
                        n_o_new    = 1'b0;
                        n_o_value  = '0;
                        n_o_visits = '0;
                        n_o_full   = 1'b1;
                    end else begin
                        ram_we     = 1'b1;
                        ram_waddr  = r_used[IDX_W-1:0];
                        ram_wdata  = {r_key, r_ret, svtu_pkg::VISIT_ONE};
                        n_used     = r_used + 1'b1;
                        n_o_index  = INDEX_W'(r_used);
                        n_o_new    = 1'b1;
                        n_o_value  = r_ret;
                        n_o_visits = svtu_pkg::VISIT_ONE;
                        n_o_full   = 1'b0;
                    end
                    n_state = svtu_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = svtu_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= svtu_pkg::S_IDLE;
            r_used    <= '0;
            r_addr    <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
            r_step    <= svtu_pkg::STEP_RESET;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_addr    <= n_addr;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
            if (i_cfg.valid) begin
                r_step <= i_cfg.data;
            end
        end
    end

    // datapath and result payload
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_ret      <= n_ret;
        r_paddr    <= n_paddr;
        r_val      <= n_val;
        r_vis      <= n_vis;
        r_neg      <= n_neg;
        r_prod     <= n_prod;
        r_o_index  <= n_o_index;
        r_o_new    <= n_o_new;
        r_o_value  <= n_o_value;
        r_o_visits <= n_o_visits;
        r_o_full   <= n_o_full;
    end

    // result channel
    assign o_result.valid        = r_o_valid;
    assign o_result.entry_index  = r_o_index;
    assign o_result.was_new      = r_o_new;
    assign o_result.value_after  = r_o_value;
    assign o_result.visits_after = r_o_visits;
    assign o_result.table_full   = r_o_full;

endmodule

FILE: bench/tb_state_value_table_update.sv
`timescale 1ns / 1ps
// self-checking testbench for state_value_table_update: random and directed board items,
// an in-bench predictor of the value table, and valid/ready idling on the item and result channels
// depends on svtu_pkg, the svtu interfaces and the design under test
module tb_state_value_table_update;
    import svtu_pkg::*;

    localparam int KEY_W       = 2 * DEF_BOARD_CELLS;
    localparam int TABLE_DEPTH = DEF_TABLE_DEPTH;
    localparam int TAIL_CYCLES = TABLE_DEPTH + 100;

    // return codes not named in the package
    localparam logic [RET_W-1:0] RET_LOSS  = 2'b11;
    localparam logic [RET_W-1:0] RET_UNDEF = 2'b10;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [RET_W-1:0] ret;
    } t_board_item;

    typedef struct {
        logic [INDEX_W-1:0]        slot_idx;
        logic                      fresh;
        logic signed [VALUE_W-1:0] value;
        logic [VISIT_W-1:0]        visits;
        logic                      full;
    } t_table_result;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    svtu_in_if  item_if ();
    svtu_out_if res_if ();
    svtu_cfg_if cfg_if ();

    state_value_table_update dut (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_item   (item_if),
        .i_cfg    (cfg_if),
        .o_result (res_if)
    );

    // predicted table contents and step size
    logic [KEY_W-1:0]   tbl_key    [TABLE_DEPTH];
    int                 tbl_value  [TABLE_DEPTH];
    logic [VISIT_W-1:0] tbl_visits [TABLE_DEPTH];
    int                 fill_count = 0;
    logic [STEP_W-1:0]  alpha      = STEP_RESET;

    t_board_item   pending_items [$];
    t_table_result outcome_queue [$];
    t_board_item   next_item;

    // record of distinct keys queued while the table had room, shared by the stimulus
    bit               seen_keys  [logic [KEY_W-1:0]];
    logic [KEY_W-1:0] entry_keys [$];

    int          items_queued   = 0;
    int          items_accepted = 0;
    int          error_count    = 0;
    int unsigned tx_idle_pct    = 0;
    int unsigned rx_idle_pct    = 0;
    bit          hold_arm       = 1'b0;
    logic        hold_on        = 1'b0;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("== FAIL ==");
        $finish;
    end

    task automatic flag_error(input string msg);
        error_count++;
        $display("ERROR at %0t: %s", $time, msg);
    endtask

    // predictor: search, update or insert, one result per item
    function automatic t_table_result apply_item(input logic [KEY_W-1:0] key,
                                                 input logic [RET_W-1:0] code);
        t_table_result     r;
        int                target;
        int                slot;
        int                moved;
        int                v;
        longint            diff;
        longint unsigned   mag;
        longint unsigned   q;
        r = '{slot_idx: '0, fresh: 1'b0, value: '0, visits: '0, full: 1'b0};
        case (code)
            RET_WIN:  target = VALUE_ONE;
            RET_DRAW: target = 0;
            default:  target = VALUE_MONE;
        endcase
        for (slot = 0; slot < fill_count; slot++) begin
            if (tbl_key[slot] == key) begin
                diff  = longint'(target) - longint'(tbl_value[slot]);
                mag   = (diff < 0) ? -diff : diff;
                q     = (mag * alpha + 64'd32768) >> 16;
                moved = (diff < 0) ? -int'(q) : int'(q);
                v     = tbl_value[slot] + moved;
                if (v > 65536)
                    v = 65536;
                if (v < -65536)
                    v = -65536;
                tbl_value[slot] = v;
                if (tbl_visits[slot] != VISIT_MAX)
                    tbl_visits[slot]++;
                r.slot_idx = slot[INDEX_W-1:0];
                r.value    = v[VALUE_W-1:0];
                r.visits   = tbl_visits[slot];
                return r;
            end
        end
        // miss on a full table drops the item
        if (fill_count >= TABLE_DEPTH) begin
            r.full = 1'b1;
            return r;
        end
        tbl_key[fill_count]    = key;
        tbl_value[fill_count]  = target;
        tbl_visits[fill_count] = VISIT_ONE;
        r.slot_idx = fill_count[INDEX_W-1:0];
        r.fresh    = 1'b1;
        r.value    = target[VALUE_W-1:0];
        r.visits   = VISIT_ONE;
        fill_count++;
        return r;
    endfunction

    task automatic check_outcome();
        t_table_result want;
        if (outcome_queue.size() == 0) begin
            flag_error($sformatf("unexpected result, entry %0d", res_if.entry_index));
            return;
        end
        want = outcome_queue.pop_front();
        if (res_if.entry_index !== want.slot_idx)
            flag_error($sformatf("entry_index %0d, want %0d", res_if.entry_index,
                                 want.slot_idx));
        if (res_if.was_new !== want.fresh)
            flag_error($sformatf("was_new %0b, want %0b (entry %0d)", res_if.was_new,
                                 want.fresh, want.slot_idx));
        if (res_if.value_after !== want.value)
            flag_error($sformatf("value_after %0d, want %0d (entry %0d)",
                                 res_if.value_after, want.value, want.slot_idx));
        if (res_if.visits_after !== want.visits)
            flag_error($sformatf("visits_after %0d, want %0d (entry %0d)",
                                 res_if.visits_after, want.visits, want.slot_idx));
        if (res_if.table_full !== want.full)
            flag_error($sformatf("table_full %0b, want %0b", res_if.table_full, want.full));
    endtask

    // item driver: predicts on each accepted transfer, then offers the next item
    always @(posedge clk) begin
        if (!rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                outcome_queue.push_back(apply_item(item_if.state_key, item_if.episode_return));
                items_accepted++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (pending_items.size() != 0 && $urandom_range(99, 0) >= tx_idle_pct) begin
                    next_item = pending_items.pop_front();
                    item_if.valid          <= 1'b1;
                    item_if.state_key      <= next_item.key;
                    item_if.episode_return <= next_item.ret;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk) begin
        if (res_if.valid && res_if.ready)
            check_outcome();
        if (!rst_n)
            res_if.ready <= 1'b0;
        else
            res_if.ready <= !hold_on && ($urandom_range(99, 0) >= rx_idle_pct);
    end

    // long receiver hold-off so the block backs up and stalls its input
    initial begin
        wait (hold_arm);
        @(posedge clk);
        hold_on <= 1'b1;
        repeat (600) @(posedge clk);
        hold_on <= 1'b0;
    end

    // stimulus
    initial begin
        logic [KEY_W-1:0] k;
        int               n;
        int               c;

        item_if.valid          = 1'b0;
        item_if.state_key      = '0;
        item_if.episode_return = '0;
        res_if.ready           = 1'b0;
        cfg_if.valid           = 1'b0;
        cfg_if.data            = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed part, default step size after reset
        tx_idle_pct = 31;
        rx_idle_pct = 57;
        queue_item(18'h00000, RET_DRAW);       // first insert, then hit on it
        queue_item(18'h00000, RET_WIN);
        queue_item(18'h3FFFF, RET_LOSS);       // all ones, cell code 3 everywhere
        queue_item(18'h3FFFF, RET_UNDEF);      // undefined return saturates to loss
        queue_item(18'h3FFFF, RET_WIN);
        queue_item(18'h15555, RET_WIN);        // board full of first player
        queue_item(18'h2AAAA, RET_LOSS);       // board full of second player
        queue_item(18'h000C0, RET_DRAW);       // one cell holding code 3
        queue_item(18'h15555, RET_UNDEF);
        queue_item(18'h00000, RET_LOSS);
        wait_drained();

        // largest step size
        write_step(16'hFFFF);
        queue_item(18'h00000, RET_WIN);
        queue_item(18'h00000, RET_LOSS);
        queue_item(18'h3FFFF, RET_WIN);
        queue_item(18'h2AAAA, RET_WIN);
        queue_item(18'h000C0, RET_UNDEF);
        wait_drained();

        // zero step size: hits leave the value alone
        write_step(16'h0000);
        queue_item(18'h00000, RET_WIN);
        queue_item(18'h15555, RET_LOSS);
        queue_item(18'h20000, RET_WIN);
        queue_item(18'h20000, RET_LOSS);
        wait_drained();

        // random part: mostly revisits of known boards, some new ones
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct = 31;
                    rx_idle_pct = 57;
                    write_step(16'($urandom_range(65535, 0)));
                    n = 170;
                end
                1: begin
                    tx_idle_pct = 57;
                    rx_idle_pct = 31;
                    write_step(16'($urandom_range(4000, 1)));
                    n = 170;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                    write_step(16'($urandom_range(65535, 0)));
                    hold_arm = 1'b1;
                    n = 160;
                end
            endcase
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(9, 0) < 3) begin
                    if ($urandom_range(1, 0) == 0) begin
                        for (c = 0; c < DEF_BOARD_CELLS; c++)
                            k[2*c +: 2] = 2'($urandom_range(2, 0));
                    end else begin
                        k = KEY_W'($urandom());
                    end
                end else begin
                    k = entry_keys[$urandom_range(entry_keys.size() - 1, 0)];
                end
                queue_item(k, pick_return());
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // queue an item and record its key among the keys that the table will hold, in entry order
    task automatic queue_item(input logic [KEY_W-1:0] key, input logic [RET_W-1:0] ret);
        t_board_item it;
        it.key = key;
        it.ret = ret;
        if (!stim_known(key) && stim_count() < TABLE_DEPTH)
            stim_add(key);
        pending_items.push_back(it);
        items_queued++;
    endtask

    function automatic logic [RET_W-1:0] pick_return();
        case ($urandom_range(9, 0))
            0, 1, 2: return RET_WIN;
            3, 4, 5: return RET_LOSS;
            6, 7, 8: return RET_DRAW;
            default: return RET_UNDEF;
        endcase
    endfunction

    task automatic wait_drained();
        while (items_accepted != items_queued || outcome_queue.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_step(input logic [STEP_W-1:0] step);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= step;
        do @(posedge clk); while (!cfg_if.ready);
        alpha = step;
        cfg_if.valid <= 1'b0;
    endtask

    function automatic bit stim_known(input logic [KEY_W-1:0] key);
        return seen_keys.exists(key);
    endfunction

    function automatic int stim_count();
        return entry_keys.size();
    endfunction

    function automatic void stim_add(input logic [KEY_W-1:0] key);
        seen_keys[key] = 1'b1;
        entry_keys.push_back(key);
    endfunction

endmodule

FILE: filelist.f
design/svtu_pkg.sv
design/svtu_if.sv
design/svtu_ram.sv
design/state_value_table_update.sv
bench/tb_state_value_table_update.sv
